/* rtl/softened_gravity_force_top_assert.svh */
// Assertion macros for the softened gravity force block
`ifndef SOFTENED_GRAVITY_FORCE_TOP_ASSERT_SVH
`define SOFTENED_GRAVITY_FORCE_TOP_ASSERT_SVH

// Check a condition at every clock edge out of reset
`define SGF_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("softened gravity force check failed");

// Check a consequence in the same cycle
`define SGF_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("softened gravity force check failed");

// Check a consequence in the next cycle
`define SGF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("softened gravity force check failed");

`endif

/* rtl/sgf_pkg.sv */
// Types and constants for the softened gravity force block
package sgf_pkg;

  localparam int FRACTION_BITS = 16;
  localparam logic [31:0] GRAVITY_RESET = 32'(1 << FRACTION_BITS);
  localparam logic [31:0] SOFTENING_RESET = 32'(50 << FRACTION_BITS);

  localparam int ADDR_W = 3;
  localparam int SQRT_STEPS = 34;
  localparam int QUOT_BITS = 48;

  localparam logic [47:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_LIMIT = 48'h8000_0000_0000;

  typedef enum logic {
    REG_GRAVITY   = 1'b0,
    REG_SOFTENING = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [31:0]        first_mass;
    logic [31:0]        second_mass;
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
  } sgf_in_t;

  typedef struct packed {
    logic signed [47:0] force_x;
    logic signed [47:0] force_y;
    logic               saturated;
  } sgf_out_t;

endpackage

/* rtl/softened_gravity_force_top.sv */
// Softened gravity force pipeline with its configuration registers
//
// Takes one body pair per cycle while pair_ready is high and returns the
// force on the first body, one result per cycle when the output is taken.
// The square root has 34 steps and the quotient 48, one step per pipeline
// stage; all stages advance together and hold while a result waits at the
// output register.
module softened_gravity_force_top (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pair_valid,
  output logic                     pair_ready,
  input  sgf_pkg::sgf_in_t         body_pair,
  output logic                     result_valid,
  input  logic                     result_ready,
  output sgf_pkg::sgf_out_t        result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [sgf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import sgf_pkg::*;

  typedef struct packed {
    logic [32:0] ax;
    logic [32:0] ay;
    logic        xpos;
    logic        ypos;
    logic [63:0] gm1;
    logic [31:0] m2;
  } s1_t;

  typedef struct packed {
    logic [65:0] sqx;
    logic [65:0] sqy;
    logic [63:0] gmlo;
    logic [63:0] gmhi;
    logic [32:0] ax;
    logic [32:0] ay;
    logic        xpos;
    logic        ypos;
  } s2_t;

  typedef struct packed {
    logic [67:0] src;
    logic [35:0] rem;
    logic [33:0] root;
    logic [95:0] gm;
    logic [32:0] ax;
    logic [32:0] ay;
    logic        xpos;
    logic        ypos;
  } sq_t;

  typedef struct packed {
    logic [34:0] dsoft;
    logic [64:0] px0;
    logic [64:0] px1;
    logic [64:0] px2;
    logic [64:0] py0;
    logic [64:0] py1;
    logic [64:0] py2;
    logic        xpos;
    logic        ypos;
  } d1_t;

  typedef struct packed {
    logic [69:0]  dsq;
    logic [34:0]  dsoft;
    logic [127:0] numx;
    logic [127:0] numy;
    logic         xpos;
    logic         ypos;
  } d2_t;

  typedef struct packed {
    logic [69:0]  dlo;
    logic [69:0]  dhi;
    logic [127:0] numx;
    logic [127:0] numy;
    logic         xpos;
    logic         ypos;
  } d3_t;

  typedef struct packed {
    logic [127:0] remx;
    logic [127:0] remy;
    logic [104:0] den;
    logic [47:0]  qx;
    logic [47:0]  qy;
    logic         ovfx;
    logic         ovfy;
    logic         zero;
    logic         xpos;
    logic         ypos;
  } dv_t;

  logic [31:0] gravity_constant;
  logic [31:0] softening_offset;
  logic        en;

  s1_t s1;
  s2_t s2;
  sq_t sq [SQRT_STEPS+1];
  d1_t d1;
  d2_t d2;
  d3_t d3;
  dv_t dv [QUOT_BITS+2];
  dv_t dv1_next;
  logic s1_valid, s2_valid, d1_valid, d2_valid, d3_valid;
  logic [SQRT_STEPS:0] sq_valid;
  logic [QUOT_BITS+1:0] dv_valid;

  assign pready = 1'b1;
  assign en = !result_valid || result_ready;
  assign pair_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_constant <= GRAVITY_RESET;
      softening_offset <= SOFTENING_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_index_t'(paddr[2]))
        REG_GRAVITY:   gravity_constant <= pwdata;
        REG_SOFTENING: softening_offset <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index_t'(paddr[2]))
      REG_GRAVITY:   prdata = gravity_constant;
      REG_SOFTENING: prdata = softening_offset;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      sq_valid     <= '0;
      d1_valid     <= 1'b0;
      d2_valid     <= 1'b0;
      d3_valid     <= 1'b0;
      dv_valid     <= '0;
      result_valid <= 1'b0;
    end else if (en) begin
      s1_valid     <= pair_valid;
      s2_valid     <= s1_valid;
      sq_valid     <= {sq_valid[SQRT_STEPS-1:0], s2_valid};
      d1_valid     <= sq_valid[SQRT_STEPS];
      d2_valid     <= d1_valid;
      d3_valid     <= d2_valid;
      dv_valid     <= {dv_valid[QUOT_BITS:0], d3_valid};
      result_valid <= dv_valid[QUOT_BITS+1];
    end
  end

  // separation, absolute values and G*m1
  logic signed [32:0] rx, ry;
  assign rx = 33'(body_pair.first_x) - 33'(body_pair.second_x);
  assign ry = 33'(body_pair.first_y) - 33'(body_pair.second_y);

  always_ff @(posedge clk) begin
    if (en) begin
      s1.ax   <= rx[32] ? 33'(-rx) : 33'(rx);
      s1.ay   <= ry[32] ? 33'(-ry) : 33'(ry);
      s1.xpos <= !rx[32] && (rx != '0);
      s1.ypos <= !ry[32] && (ry != '0);
      s1.gm1  <= 64'(gravity_constant) * 64'(body_pair.first_mass);
      s1.m2   <= body_pair.second_mass;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2.sqx  <= 66'(s1.ax) * 66'(s1.ax);
      s2.sqy  <= 66'(s1.ay) * 66'(s1.ay);
      s2.gmlo <= 64'(s1.gm1[31:0]) * 64'(s1.m2);
      s2.gmhi <= 64'(s1.gm1[63:32]) * 64'(s1.m2);
      s2.ax   <= s1.ax;
      s2.ay   <= s1.ay;
      s2.xpos <= s1.xpos;
      s2.ypos <= s1.ypos;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq[0].src  <= 68'(s2.sqx) + 68'(s2.sqy);
      sq[0].rem  <= '0;
      sq[0].root <= '0;
      sq[0].gm   <= 96'(s2.gmlo) + {s2.gmhi, 32'b0};
      sq[0].ax   <= s2.ax;
      sq[0].ay   <= s2.ay;
      sq[0].xpos <= s2.xpos;
      sq[0].ypos <= s2.ypos;
    end
  end

  // integer square root, two bits of the sum per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [37:0] rem_sh;
    logic [37:0] trial;
    logic        take;
    assign rem_sh = {sq[k].rem, sq[k].src[67:66]};
    assign trial  = {2'b0, sq[k].root, 2'b01};
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        sq[k+1].src  <= {sq[k].src[65:0], 2'b0};
        sq[k+1].rem  <= take ? 36'(rem_sh - trial) : rem_sh[35:0];
        sq[k+1].root <= {sq[k].root[32:0], take};
        sq[k+1].gm   <= sq[k].gm;
        sq[k+1].ax   <= sq[k].ax;
        sq[k+1].ay   <= sq[k].ay;
        sq[k+1].xpos <= sq[k].xpos;
        sq[k+1].ypos <= sq[k].ypos;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1.dsoft <= 35'(sq[SQRT_STEPS].root) + 35'(softening_offset);
      d1.px0   <= 65'(sq[SQRT_STEPS].gm[31:0]) * 65'(sq[SQRT_STEPS].ax);
      d1.px1   <= 65'(sq[SQRT_STEPS].gm[63:32]) * 65'(sq[SQRT_STEPS].ax);
      d1.px2   <= 65'(sq[SQRT_STEPS].gm[95:64]) * 65'(sq[SQRT_STEPS].ax);
      d1.py0   <= 65'(sq[SQRT_STEPS].gm[31:0]) * 65'(sq[SQRT_STEPS].ay);
      d1.py1   <= 65'(sq[SQRT_STEPS].gm[63:32]) * 65'(sq[SQRT_STEPS].ay);
      d1.py2   <= 65'(sq[SQRT_STEPS].gm[95:64]) * 65'(sq[SQRT_STEPS].ay);
      d1.xpos  <= sq[SQRT_STEPS].xpos;
      d1.ypos  <= sq[SQRT_STEPS].ypos;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2.dsq   <= 70'(d1.dsoft) * 70'(d1.dsoft);
      d2.dsoft <= d1.dsoft;
      d2.numx  <= 128'(d1.px0) + (128'(d1.px1) << 32) + (128'(d1.px2) << 64);
      d2.numy  <= 128'(d1.py0) + (128'(d1.py1) << 32) + (128'(d1.py2) << 64);
      d2.xpos  <= d1.xpos;
      d2.ypos  <= d1.ypos;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3.dlo  <= 70'(d2.dsq[34:0]) * 70'(d2.dsoft);
      d3.dhi  <= 70'(d2.dsq[69:35]) * 70'(d2.dsoft);
      d3.numx <= d2.numx;
      d3.numy <= d2.numy;
      d3.xpos <= d2.xpos;
      d3.ypos <= d2.ypos;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].remx <= d3.numx;
      dv[0].remy <= d3.numy;
      dv[0].den  <= 105'(d3.dlo) + (105'(d3.dhi) << 35);
      dv[0].qx   <= '0;
      dv[0].qy   <= '0;
      dv[0].ovfx <= 1'b0;
      dv[0].ovfy <= 1'b0;
      dv[0].zero <= 1'b0;
      dv[0].xpos <= d3.xpos;
      dv[0].ypos <= d3.ypos;
    end
  end

  // quotient overflow and zero divisor
  always_comb begin
    dv1_next      = dv[0];
    dv1_next.ovfx = 153'(dv[0].remx) >= {dv[0].den, 48'b0};
    dv1_next.ovfy = 153'(dv[0].remy) >= {dv[0].den, 48'b0};
    dv1_next.zero = dv[0].den == '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[1] <= dv1_next;
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar j = 0; j < QUOT_BITS; j++) begin : g_div
    localparam int B = QUOT_BITS - 1 - j;
    logic [152:0] den_sh;
    logic         takex, takey;
    dv_t          dv_next;
    assign den_sh = 153'(dv[j+1].den) << B;
    assign takex  = 153'(dv[j+1].remx) >= den_sh;
    assign takey  = 153'(dv[j+1].remy) >= den_sh;

    always_comb begin
      dv_next       = dv[j+1];
      dv_next.qx[B] = takex;
      dv_next.qy[B] = takey;
      if (takex) begin
        dv_next.remx = dv[j+1].remx - den_sh[127:0];
      end
      if (takey) begin
        dv_next.remy = dv[j+1].remy - den_sh[127:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv[j+2] <= dv_next;
      end
    end
  end

  // sign and clamp
  dv_t  fin;
  logic [47:0] fx, fy;
  logic        satx, saty;
  assign fin = dv[QUOT_BITS+1];

  always_comb begin
    satx = 1'b0;
    saty = 1'b0;
    if (fin.zero) begin
      fx = '0;
    end else if (fin.xpos) begin
      if (fin.ovfx || (fin.qx[47] && (fin.qx[46:0] != '0))) begin
        fx   = NEG_LIMIT;
        satx = 1'b1;
      end else begin
        fx = 48'(-fin.qx);
      end
    end else begin
      if (fin.ovfx || fin.qx[47]) begin
        fx   = POS_LIMIT;
        satx = 1'b1;
      end else begin
        fx = fin.qx;
      end
    end
    if (fin.zero) begin
      fy = '0;
    end else if (fin.ypos) begin
      if (fin.ovfy || (fin.qy[47] && (fin.qy[46:0] != '0))) begin
        fy   = NEG_LIMIT;
        saty = 1'b1;
      end else begin
        fy = 48'(-fin.qy);
      end
    end else begin
      if (fin.ovfy || fin.qy[47]) begin
        fy   = POS_LIMIT;
        saty = 1'b1;
      end else begin
        fy = fin.qy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.force_x   <= fx;
      result.force_y   <= fy;
      result.saturated <= satx || saty;
    end
  end

endmodule

/* rtl/sgf_checker.sv */
// Port-level checks for the softened gravity force block, bound to the top level
`include "softened_gravity_force_top_assert.svh"

module sgf_checker (
  input logic              clk,
  input logic              rst,
  input logic              pair_ready,
  input logic              result_valid,
  input logic              result_ready,
  input sgf_pkg::sgf_out_t result,
  input logic              pready
);
  import sgf_pkg::*;

  `SGF_ASSERT_ALWAYS(a_pready_high, pready)
  `SGF_ASSERT_NOW(a_ready_when_empty, !result_valid, pair_ready)
  `SGF_ASSERT_NOW(a_stall_blocks_input, result_valid && !result_ready, !pair_ready)
  `SGF_ASSERT_NEXT(a_stalled_beat_holds, result_valid && !result_ready,
                   result_valid && $stable(result))
  `SGF_ASSERT_NOW(a_saturated_at_limit, result_valid && result.saturated,
                  result.force_x == POS_LIMIT || result.force_x == NEG_LIMIT ||
                  result.force_y == POS_LIMIT || result.force_y == NEG_LIMIT)

endmodule

bind softened_gravity_force_top sgf_checker u_sgf_checker (
  .clk          (clk),
  .rst          (rst),
  .pair_ready   (pair_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result),
  .pready       (pready)
);
